[hdl/flst_pkg.sv]
`timescale 1ns / 1ps

package flst_pkg;

	// Table geometry
	localparam int SLOTS      = 256;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int TYPE_COUNT = 4;

	// Field widths
	localparam int OP_W   = 2;
	localparam int ID_W   = 9;
	localparam int TY_W   = 2;
	localparam int STEP_W = 10;
	localparam int TYPE_W = 3;
	localparam int CNT_W  = 9;
	localparam int ST_W   = 2;

	// Walk registers: step count lowered by one when the slot id is none, live slots still to pass,
	// and the walking position
	localparam int WM_W  = STEP_W + 1;
	localparam int WN_W  = STEP_W;
	localparam int NXT_W = STEP_W;

	localparam logic [TYPE_W-1:0] TYPE_FREE = TYPE_W'(TYPE_COUNT);
	localparam logic [TYPE_W-1:0] TYPE_MAX  = TYPE_W'(TYPE_COUNT - 1);
	localparam logic [ID_W-1:0]   ID_NONE   = '1;

	typedef enum logic [OP_W-1:0] {
		OP_SAVE    = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Memory read address source
	typedef enum logic [1:0] {
		RS_IN   = 2'd0,
		RS_CUR  = 2'd1,
		RS_WALK = 2'd2
	} rsrc_t;

	// Datapath action for the current cycle
	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_POP        = 4'd1,
		ACT_GROW       = 4'd2,
		ACT_FULL       = 4'd3,
		ACT_RANGE      = 4'd4,
		ACT_OVERWRITE  = 4'd5,
		ACT_FILL_START = 4'd6,
		ACT_UL_STEP    = 4'd7,
		ACT_UL_PATCH   = 4'd8,
		ACT_REMOVE     = 4'd9,
		ACT_WALK_INIT  = 4'd10,
		ACT_WALK_STEP  = 4'd11,
		ACT_WALK_END   = 4'd12,
		ACT_QUERY      = 4'd13
	} act_t;

	typedef struct packed {
		logic  load_in;
		logic  load_out;
		rsrc_t rd_src;
		act_t  act;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic sid_neg1;
		logic in_range;
		logic head_valid;
		logic table_full;
		logic slot_free;
		logic head_is_sid;
		logic ul_hit;
		logic ul_end;
		logic walk_done;
	} stat_t;

endpackage

[hdl/free_list_slot_table.sv]
`timescale 1ns / 1ps

// Channel  Direction  Ports                Payload
// s_axis   in         tvalid/tready/tdata  op, slot_id, traj_type, step_count
// m_axis   out        tvalid/tready/tdata  result_id, result_type, live_count, status
//
// One word at a time: a word is accepted only while idle, then read, executed and loaded out in turn.
// Save onto a free slot adds a fill step, after a walk of the free list to the entry ahead of the slot.
// Advance walks the table slot by slot (up to 256 slots walked);
// its first walk step only primes the registered type memory read.
// Reset clears the free-list head, the high-water mark and the live count; no clearing pass.
// A result waiting on m_axis does not block the next accept; it stalls only the next result.

module free_list_slot_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // op[1:0], slot_id[10:2], traj_type[12:11],
	                                   // step_count[22:13], zero[23]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // result_id[8:0], result_type[11:9],
	                                   // live_count[20:12], status[22:21], zero[23]
);

	flst_pkg::cmd_t                      cmd;
	flst_pkg::stat_t                     stat;
	logic signed [flst_pkg::ID_W-1:0]    result_id;
	logic        [flst_pkg::TYPE_W-1:0]  result_type;
	logic        [flst_pkg::CNT_W-1:0]   live_count;
	flst_pkg::status_t                   status;

	flst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	flst_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (flst_pkg::op_t'(s_axis_tdata[1:0])),
		.slot_id     (s_axis_tdata[10:2]),
		.traj_type   (s_axis_tdata[12:11]),
		.step_count  (s_axis_tdata[22:13]),
		.result_id   (result_id),
		.result_type (result_type),
		.live_count  (live_count),
		.status      (status)
	);

	// Pack the result word
	assign m_axis_tdata = {1'b0, status, live_count, result_type, result_id};

	// One word in flight: no second accept right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("accepted a word while another is in flight");

	// Failed words carry no slot
	a_err_none: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status != flst_pkg::ST_OK) |-> (result_id == flst_pkg::ID_NONE))
		else $error("error result carries a slot id");

	// Live count never exceeds the table
	a_live_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (live_count <= flst_pkg::CNT_W'(flst_pkg::SLOTS)))
		else $error("live count above table size");

	// Type is reported only by a successful query
	a_type_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result_type != '0) |-> (status == flst_pkg::ST_OK))
		else $error("type reported on failed word");

endmodule

[hdl/flst_dp.sv]
`timescale 1ns / 1ps

module flst_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  flst_pkg::cmd_t                       cmd,
	output flst_pkg::stat_t                      stat,
	input  flst_pkg::op_t                        op,
	input  logic signed [flst_pkg::ID_W-1:0]     slot_id,
	input  logic        [flst_pkg::TY_W-1:0]     traj_type,
	input  logic signed [flst_pkg::STEP_W-1:0]   step_count,
	output logic signed [flst_pkg::ID_W-1:0]     result_id,
	output logic        [flst_pkg::TYPE_W-1:0]   result_type,
	output logic        [flst_pkg::CNT_W-1:0]    live_count,
	output flst_pkg::status_t                    status
);

	// Latched word
	flst_pkg::op_t                        op_q;
	logic signed [flst_pkg::ID_W-1:0]     sid_q;
	logic        [flst_pkg::TYPE_W-1:0]   ty_q;
	logic signed [flst_pkg::STEP_W-1:0]   n_q;

	// Table state
	logic signed [flst_pkg::ID_W-1:0]     free_head_q;
	logic        [flst_pkg::CNT_W-1:0]    used_q;
	logic        [flst_pkg::CNT_W-1:0]    live_q;

	// Free-list walk and advance walk
	logic        [flst_pkg::IDX_W-1:0]    cur_q;
	logic signed [flst_pkg::ID_W-1:0]     sid_link_q;
	logic signed [flst_pkg::NXT_W-1:0]    nxt_q;
	logic        [flst_pkg::WN_W-1:0]     wn_q;
	logic                                 dn_q;
	logic                                 pend_q;

	// Result of the current word
	logic signed [flst_pkg::ID_W-1:0]     rid_q;
	logic        [flst_pkg::TYPE_W-1:0]   rtype_q;
	flst_pkg::status_t                    rstat_q;

	// Memories
	logic        [flst_pkg::TYPE_W-1:0]   type_mem [flst_pkg::SLOTS];
	logic signed [flst_pkg::ID_W-1:0]     link_mem [flst_pkg::SLOTS];
	logic        [flst_pkg::TYPE_W-1:0]   type_rd;
	logic signed [flst_pkg::ID_W-1:0]     link_rd;

	logic        [flst_pkg::IDX_W-1:0]    raddr;
	logic        [flst_pkg::IDX_W-1:0]    waddr;
	logic                                 type_we;
	logic                                 link_we;
	logic        [flst_pkg::TYPE_W-1:0]   wtype;
	logic signed [flst_pkg::ID_W-1:0]     wlink;

	logic        [flst_pkg::TYPE_W-1:0]   ty_in;
	logic signed [flst_pkg::NXT_W-1:0]    nxt_inc;
	logic signed [flst_pkg::WM_W-1:0]     walk_m;
	logic        [flst_pkg::WM_W-1:0]     walk_mag;
	logic                                 sid_neg1;
	logic                                 in_range;
	logic                                 slot_free;
	logic                                 nxt_out;

	// Clamp the stored type so it never reads as free
	assign ty_in = (flst_pkg::TYPE_W'(traj_type) >= flst_pkg::TYPE_FREE) ?
		flst_pkg::TYPE_MAX : flst_pkg::TYPE_W'(traj_type);

	assign sid_neg1  = (sid_q == flst_pkg::ID_NONE);
	assign in_range  = !sid_q[flst_pkg::ID_W-1] &&
		(flst_pkg::CNT_W'(sid_q[flst_pkg::IDX_W-1:0]) < used_q);
	assign slot_free = (type_rd == flst_pkg::TYPE_FREE);

	assign nxt_inc  = dn_q ? (nxt_q - flst_pkg::NXT_W'(1)) : (nxt_q + flst_pkg::NXT_W'(1));
	assign nxt_out  = nxt_q[flst_pkg::NXT_W-1] || (nxt_q[flst_pkg::ID_W-1:0] >= used_q);
	assign walk_m   = {n_q[flst_pkg::STEP_W-1], n_q} - flst_pkg::WM_W'(sid_neg1);
	assign walk_mag = walk_m[flst_pkg::WM_W-1] ? (-walk_m) : walk_m;

	// Status to the controller
	assign stat.op          = op_q;
	assign stat.sid_neg1    = sid_neg1;
	assign stat.in_range    = in_range;
	assign stat.head_valid  = !free_head_q[flst_pkg::ID_W-1];
	assign stat.table_full  = (used_q == flst_pkg::CNT_W'(flst_pkg::SLOTS));
	assign stat.slot_free   = slot_free;
	assign stat.head_is_sid = (free_head_q == sid_q);
	assign stat.ul_hit      = (link_rd == sid_q);
	assign stat.ul_end      = link_rd[flst_pkg::ID_W-1];
	assign stat.walk_done   = (wn_q == '0) || nxt_out;

	// Select read address
	always_comb begin
		case (cmd.rd_src)
			flst_pkg::RS_CUR:  raddr = cur_q;
			flst_pkg::RS_WALK: raddr = pend_q ? nxt_inc[flst_pkg::IDX_W-1:0] :
				nxt_q[flst_pkg::IDX_W-1:0];
			default:           raddr = (op_q == flst_pkg::OP_SAVE && sid_neg1) ?
				free_head_q[flst_pkg::IDX_W-1:0] : sid_q[flst_pkg::IDX_W-1:0];
		endcase
	end

	// Decode memory writes
	always_comb begin
		type_we = 1'b0;
		link_we = 1'b0;
		waddr   = sid_q[flst_pkg::IDX_W-1:0];
		wtype   = ty_q;
		wlink   = flst_pkg::ID_NONE;
		unique case (cmd.act)
			flst_pkg::ACT_POP: begin
				type_we = 1'b1;
				link_we = 1'b1;
				waddr   = free_head_q[flst_pkg::IDX_W-1:0];
			end
			flst_pkg::ACT_GROW: begin
				type_we = 1'b1;
				link_we = 1'b1;
				waddr   = used_q[flst_pkg::IDX_W-1:0];
			end
			flst_pkg::ACT_OVERWRITE: begin
				type_we = 1'b1;
				link_we = 1'b1;
			end
			flst_pkg::ACT_UL_PATCH: begin
				link_we = 1'b1;
				waddr   = cur_q;
				wlink   = sid_link_q;
			end
			flst_pkg::ACT_REMOVE: begin
				type_we = !slot_free;
				link_we = !slot_free;
				wtype   = flst_pkg::TYPE_FREE;
				wlink   = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// Type and link memories with registered read
	always_ff @(posedge clk) begin
		if (type_we) begin
			type_mem[waddr] <= wtype;
		end
		type_rd <= type_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[waddr] <= wlink;
		end
		link_rd <= link_mem[raddr];
	end

	// Table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= flst_pkg::ID_NONE;
			used_q      <= '0;
			live_q      <= '0;
			pend_q      <= 1'b0;
		end else begin
			unique case (cmd.act)
				flst_pkg::ACT_POP: begin
					free_head_q <= link_rd;
					live_q      <= live_q + 1'b1;
				end
				flst_pkg::ACT_GROW: begin
					used_q <= used_q + 1'b1;
					live_q <= live_q + 1'b1;
				end
				flst_pkg::ACT_FILL_START: begin
					live_q <= live_q + 1'b1;
					if (free_head_q == sid_q) begin
						free_head_q <= link_rd;
					end
				end
				flst_pkg::ACT_REMOVE: begin
					if (!slot_free) begin
						free_head_q <= sid_q;
						live_q      <= live_q - 1'b1;
					end
				end
				flst_pkg::ACT_WALK_INIT: pend_q <= 1'b0;
				flst_pkg::ACT_WALK_STEP: pend_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Word latch, walk registers and result
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op;
			sid_q <= slot_id;
			ty_q  <= ty_in;
			n_q   <= step_count;
		end
		unique case (cmd.act)
			flst_pkg::ACT_POP: begin
				rid_q   <= free_head_q;
				rtype_q <= '0;
				rstat_q <= flst_pkg::ST_OK;
			end
			flst_pkg::ACT_GROW: begin
				rid_q   <= used_q;
				rtype_q <= '0;
				rstat_q <= flst_pkg::ST_OK;
			end
			flst_pkg::ACT_FULL: begin
				rid_q   <= flst_pkg::ID_NONE;
				rtype_q <= '0;
				rstat_q <= flst_pkg::ST_FULL;
			end
			flst_pkg::ACT_RANGE: begin
				rid_q   <= flst_pkg::ID_NONE;
				rtype_q <= '0;
				rstat_q <= flst_pkg::ST_RANGE;
			end
			flst_pkg::ACT_OVERWRITE, flst_pkg::ACT_REMOVE: begin
				rid_q   <= sid_q;
				rtype_q <= '0;
				rstat_q <= flst_pkg::ST_OK;
			end
			flst_pkg::ACT_FILL_START: begin
				sid_link_q <= link_rd;
				cur_q      <= free_head_q[flst_pkg::IDX_W-1:0];
			end
			flst_pkg::ACT_UL_STEP: cur_q <= link_rd[flst_pkg::IDX_W-1:0];
			flst_pkg::ACT_WALK_INIT: begin
				nxt_q <= sid_neg1 ? '0 : flst_pkg::NXT_W'(sid_q);
				dn_q  <= walk_m[flst_pkg::WM_W-1];
				wn_q  <= walk_mag[flst_pkg::WN_W-1:0];
			end
			flst_pkg::ACT_WALK_STEP: begin
				if (pend_q) begin
					nxt_q <= nxt_inc;
					wn_q  <= wn_q - flst_pkg::WN_W'(!slot_free);
				end
			end
			flst_pkg::ACT_WALK_END: begin
				rid_q   <= nxt_out ? flst_pkg::ID_NONE : nxt_q[flst_pkg::ID_W-1:0];
				rtype_q <= '0;
				rstat_q <= flst_pkg::ST_OK;
			end
			flst_pkg::ACT_QUERY: begin
				rid_q   <= sid_q;
				rtype_q <= type_rd;
				rstat_q <= flst_pkg::ST_OK;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_id   <= rid_q;
			result_type <= rtype_q;
			live_count  <= live_q;
			status      <= rstat_q;
		end
	end

endmodule

[hdl/flst_ctrl.sv]
`timescale 1ns / 1ps

module flst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  flst_pkg::stat_t stat,
	output flst_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_READ   = 8'b0000_0010,
		S_EXEC   = 8'b0000_0100,
		S_UL_RD  = 8'b0000_1000,
		S_UL_CHK = 8'b0001_0000,
		S_FILL   = 8'b0010_0000,
		S_WALK   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Sequence one word through read, execute and any walk
	always_comb begin
		state_d      = state_q;
		cmd.load_in  = 1'b0;
		cmd.load_out = 1'b0;
		cmd.rd_src   = flst_pkg::RS_IN;
		cmd.act      = flst_pkg::ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_DONE;
				unique case (stat.op)
					flst_pkg::OP_SAVE: begin
						if (stat.sid_neg1) begin
							if (stat.head_valid) begin
								cmd.act = flst_pkg::ACT_POP;
							end else if (!stat.table_full) begin
								cmd.act = flst_pkg::ACT_GROW;
							end else begin
								cmd.act = flst_pkg::ACT_FULL;
							end
						end else if (!stat.in_range) begin
							cmd.act = flst_pkg::ACT_RANGE;
						end else if (stat.slot_free) begin
							cmd.act = flst_pkg::ACT_FILL_START;
							state_d = stat.head_is_sid ? S_FILL : S_UL_RD;
						end else begin
							cmd.act = flst_pkg::ACT_OVERWRITE;
						end
					end
					flst_pkg::OP_REMOVE: begin
						cmd.act = stat.in_range ? flst_pkg::ACT_REMOVE : flst_pkg::ACT_RANGE;
					end
					flst_pkg::OP_ADVANCE: begin
						if (stat.sid_neg1 || stat.in_range) begin
							cmd.act = flst_pkg::ACT_WALK_INIT;
							state_d = S_WALK;
						end else begin
							cmd.act = flst_pkg::ACT_RANGE;
						end
					end
					default: begin
						cmd.act = stat.in_range ? flst_pkg::ACT_QUERY : flst_pkg::ACT_RANGE;
					end
				endcase
			end
			S_UL_RD: begin
				cmd.rd_src = flst_pkg::RS_CUR;
				state_d    = S_UL_CHK;
			end
			S_UL_CHK: begin
				if (stat.ul_hit) begin
					cmd.act = flst_pkg::ACT_UL_PATCH;
					state_d = S_FILL;
				end else if (stat.ul_end) begin
					state_d = S_FILL;
				end else begin
					cmd.act = flst_pkg::ACT_UL_STEP;
					state_d = S_UL_RD;
				end
			end
			S_FILL: begin
				cmd.act = flst_pkg::ACT_OVERWRITE;
				state_d = S_DONE;
			end
			S_WALK: begin
				cmd.rd_src = flst_pkg::RS_WALK;
				if (stat.walk_done) begin
					cmd.act = flst_pkg::ACT_WALK_END;
					state_d = S_DONE;
				end else begin
					cmd.act = flst_pkg::ACT_WALK_STEP;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and the output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
